@@ sv/actg_pkg.sv @@
// actg_pkg: shared types, constants and sine table function for the click tone generator
// no dependencies; used by every other file of the block
`default_nettype none

package actg_pkg;

    // payload widths
    localparam int SAMPLE_W  = 16;
    localparam int LEN_W     = 16;
    localparam int STEP_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_LEN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_LEN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BURST_LEN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_ACCENT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_NORMAL = 3'd4;

    // configuration reset values
    localparam logic [LEN_W-1:0]  RST_ATTACK_LEN  = 16'd441;
    localparam logic [LEN_W-1:0]  RST_DECAY_LEN   = 16'd2205;
    localparam logic [LEN_W-1:0]  RST_BURST_LEN   = 16'd4410;
    localparam logic [STEP_W-1:0] RST_STEP_ACCENT = 32'd85704562;
    localparam logic [STEP_W-1:0] RST_STEP_NORMAL = 32'd42852281;

    // envelope divider: quotient is below 2^15
    localparam int DIV_STEPS = 15;
    localparam int DIV_CNT_W = 4;
    localparam int ENV_W     = 17;
    localparam logic [ENV_W-1:0] ENV_UNITY = 17'd32768;

    localparam real HALF_PI = 1.5707963267948966;

    // controller to datapath commands
    typedef struct packed {
        logic start;     // request accepted: step the burst state, read sine, load divider
        logic div_step;  // one restoring division step
        logic mul;       // envelope times sine
        logic load_out;  // move the sample into the output register
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic div_last;  // current division step is the final one
    } t_dp_sts;

    // round(32767*sin(2*pi*k/n)) with n = 2^lg, quarter-wave folded like the table builder
    function automatic logic signed [SAMPLE_W-1:0] sine_word(input int k, input int lg);
        int  q;
        int  r;
        int  n;
        int  v;
        real x;
        n = 1 << lg;
        q = (4 * k) >> lg;
        r = (4 * k) & (n - 1);
        if ((q & 1) == 1) begin
            r = n - r;
        end
        x = HALF_PI * $itor(r) * (2.0 ** (-lg));
        v = $rtoi(32767.0 * $sin(x) + 0.5);
        if (q >= 2) begin
            v = -v;
        end
        return v[SAMPLE_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ sv/actg_if.sv @@
// actg_if: valid/ready channel interfaces for the click tone generator
// depends on actg_pkg for payload widths
`default_nettype none

// input channel: one request per sample tick
interface actg_in_if;
    logic valid;
    logic ready;
    logic trigger;
    logic accent;

    modport source (output valid, output trigger, output accent, input ready);
    modport sink   (input valid, input trigger, input accent, output ready);
endinterface

// output channel: one sample per request
interface actg_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [actg_pkg::SAMPLE_W-1:0]  sample;
    logic                                  busy_res;

    modport source (output valid, output sample, output busy_res, input ready);
    modport sink   (input valid, input sample, input busy_res, output ready);
endinterface

// configuration write channel
interface actg_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [actg_pkg::CFG_IDX_W-1:0]    index;
    logic [actg_pkg::CFG_DAT_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ sv/accented_click_tone_generator.sv @@
// accented_click_tone_generator: top level, joins controller, datapath and channels
// depends on actg_pkg, actg_if, actg_ctrl and actg_dp
//
//  channel  | dir | payload              | handshake
//  ---------+-----+----------------------+-----------------------------
//  i_in     | in  | trigger, accent      | valid/ready, one per tick
//  o_out    | out | sample, busy_res     | valid/ready, one per request
//  i_cfg    | in  | index, data          | valid/ready, ready held high
//
// a request is taken only when the sequencer is idle; it then passes through the accept step,
// 15 steps of the serial envelope divider, one multiply and one output load that waits
// for a free output slot, after which the next request is taken.
// the output register lets a new request start while the last sample waits.
// synchronous active-low reset returns config registers to defaults and the burst to silence.
`default_nettype none

module accented_click_tone_generator #(
    parameter int SINE_ENTRIES = 1024,
    parameter int INDEX_BITS   = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    actg_in_if.sink       i_in,
    actg_out_if.source    o_out,
    actg_cfg_if.sink      i_cfg
);

    actg_pkg::t_dp_cmd w_cmd;
    actg_pkg::t_dp_sts w_sts;
    logic              w_in_ready;
    logic              w_out_valid;

    // configuration is always taken
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

    actg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    actg_dp #(
        .SINE_ENTRIES (SINE_ENTRIES),
        .INDEX_BITS   (INDEX_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_trigger   (i_in.trigger),
        .i_accent    (i_in.accent),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .o_sample    (o_out.sample),
        .o_busy_res  (o_out.busy_res)
    );

endmodule

`default_nettype wire

@@ sv/actg_ctrl.sv @@
// actg_ctrl: sequencing state machine of the click tone generator
// depends on actg_pkg for command and status types
`default_nettype none

module actg_ctrl (
    input  wire                logic        i_clk,
    input  wire                logic        i_rst_n,
    input  wire                logic        i_in_valid,
    output logic                            o_in_ready,
    output logic                            o_out_valid,
    input  wire                logic        i_out_ready,
    output actg_pkg::t_dp_cmd               o_cmd,
    input  wire actg_pkg::t_dp_sts          i_sts
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_MUL  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;
    logic   w_slot_free;

    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_slot_free = !r_out_valid || i_out_ready;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // next state and commands
    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.start    = w_accept;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (w_slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output valid: set on load, cleared when the sample is taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

@@ sv/actg_dp.sv @@
// actg_dp: burst state, config registers, sine table, serial envelope divider, multiplier
// depends on actg_pkg for widths, register indexes, sine function and command types
`default_nettype none

module actg_dp #(
    parameter int SINE_ENTRIES = 1024,
    parameter int INDEX_BITS   = 16
) (
    input  wire  logic                                   i_clk,
    input  wire  logic                                   i_rst_n,
    input  wire  actg_pkg::t_dp_cmd                      i_cmd,
    output actg_pkg::t_dp_sts                            o_sts,
    input  wire  logic                                   i_trigger,
    input  wire  logic                                   i_accent,
    input  wire  logic                                   i_cfg_we,
    input  wire  logic [actg_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire  logic [actg_pkg::CFG_DAT_W-1:0]         i_cfg_data,
    output logic signed [actg_pkg::SAMPLE_W-1:0]         o_sample,
    output logic                                         o_busy_res
);

    localparam int ADDR_W = $clog2(SINE_ENTRIES);
    localparam int LW     = actg_pkg::LEN_W;
    localparam int SW     = actg_pkg::STEP_W;
    localparam int CW     = ((INDEX_BITS > LW) ? INDEX_BITS : LW) + 1;
    localparam int QW     = actg_pkg::DIV_STEPS;
    localparam int PW     = actg_pkg::ENV_W + 1 + actg_pkg::SAMPLE_W;

    // configuration registers
    logic [LW-1:0] r_attack, r_decay, r_burst;
    logic [SW-1:0] r_step_acc, r_step_nrm;

    // burst state
    logic [SW-1:0]         r_phase;
    logic [INDEX_BITS-1:0] r_index;
    logic                  r_sounding;
    logic                  r_tone_high;

    // per-request work registers
    logic                                 r_busy;
    logic                                 r_flat;
    logic signed [actg_pkg::SAMPLE_W-1:0] r_sine;
    logic [LW-1:0]                        r_rem;
    logic [LW-1:0]                        r_div;
    logic [QW-1:0]                        r_quot;
    logic [actg_pkg::DIV_CNT_W-1:0]       r_div_cnt;
    logic signed [PW-1:0]                 r_prod;
    logic signed [actg_pkg::SAMPLE_W-1:0] r_sample;
    logic                                 r_busy_out;

    // sine table, read through a register
    logic signed [actg_pkg::SAMPLE_W-1:0] w_rom [SINE_ENTRIES];

    for (genvar g = 0; g < SINE_ENTRIES; g++) begin : g_rom
        assign w_rom[g] = actg_pkg::sine_word(g, ADDR_W);
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack   <= actg_pkg::RST_ATTACK_LEN;
            r_decay    <= actg_pkg::RST_DECAY_LEN;
            r_burst    <= actg_pkg::RST_BURST_LEN;
            r_step_acc <= actg_pkg::RST_STEP_ACCENT;
            r_step_nrm <= actg_pkg::RST_STEP_NORMAL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                actg_pkg::REG_ATTACK_LEN:  r_attack   <= i_cfg_data[LW-1:0];
                actg_pkg::REG_DECAY_LEN:   r_decay    <= i_cfg_data[LW-1:0];
                actg_pkg::REG_BURST_LEN:   r_burst    <= i_cfg_data[LW-1:0];
                actg_pkg::REG_STEP_ACCENT: r_step_acc <= i_cfg_data[SW-1:0];
                actg_pkg::REG_STEP_NORMAL: r_step_nrm <= i_cfg_data[SW-1:0];
                default: begin
                end
            endcase
        end
    end

    // burst step on a new request: trigger restart, end checks, slope choice
    logic [SW-1:0]         w_phase0;
    logic [INDEX_BITS-1:0] w_idx0;
    logic                  w_snd0;
    logic                  w_high0;
    logic                  w_snd1;
    logic [INDEX_BITS-1:0] w_idx_nxt;
    logic [CW-1:0]         w_idx_x;
    logic [CW-1:0]         w_burst_x;
    logic                  w_in_attack;
    logic                  w_in_decay;
    logic [ADDR_W-1:0]     w_addr;
    logic [LW-1:0]         w_num;
    logic [LW-1:0]         w_den;

    always_comb begin
        w_phase0    = i_trigger ? '0 : r_phase;
        w_idx0      = i_trigger ? '0 : r_index;
        w_snd0      = i_trigger || r_sounding;
        w_high0     = i_trigger ? i_accent : r_tone_high;
        w_idx_x     = CW'(w_idx0);
        w_burst_x   = CW'(r_burst);
        w_snd1      = w_snd0 && (w_idx_x < w_burst_x);
        w_idx_nxt   = w_idx0 + INDEX_BITS'(1);
        w_in_attack = w_idx_x < CW'(r_attack);
        w_in_decay  = (w_idx_x + CW'(r_decay)) > w_burst_x;
        w_addr      = w_phase0[SW-1 -: ADDR_W];
        if (w_in_attack) begin
            w_num = LW'(w_idx0);
            w_den = r_attack;
        end else begin
            w_num = LW'(w_burst_x - w_idx_x);
            w_den = r_decay;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_index     <= '0;
            r_sounding  <= 1'b0;
            r_tone_high <= 1'b0;
        end else if (i_cmd.start) begin
            r_tone_high <= w_high0;
            if (w_snd1) begin
                r_phase    <= w_phase0 + (w_high0 ? r_step_acc : r_step_nrm);
                r_index    <= w_idx_nxt;
                r_sounding <= CW'(w_idx_nxt) < w_burst_x;
            end else begin
                r_phase    <= w_phase0;
                r_index    <= w_idx0;
                r_sounding <= 1'b0;
            end
        end
    end

    // restoring division, one quotient bit per step
    logic [LW:0] w_rem2;
    logic        w_ge;

    assign w_rem2 = {r_rem, 1'b0};
    assign w_ge   = w_rem2 >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.start) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt + actg_pkg::DIV_CNT_W'(1);
        end
    end

    assign o_sts.div_last =
        (r_div_cnt == actg_pkg::DIV_CNT_W'(actg_pkg::DIV_STEPS - 1));

    // payload registers
    logic [actg_pkg::ENV_W-1:0] w_env;

    assign w_env = r_flat ? actg_pkg::ENV_UNITY : actg_pkg::ENV_W'(r_quot);

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_busy <= w_snd1;
            r_flat <= !w_in_attack && !w_in_decay;
            r_sine <= w_rom[w_addr];
            r_rem  <= w_num;
            r_div  <= w_den;
            r_quot <= '0;
        end
        if (i_cmd.div_step) begin
            r_quot <= {r_quot[QW-2:0], w_ge};
            r_rem  <= w_ge ? LW'(w_rem2 - {1'b0, r_div}) : w_rem2[LW-1:0];
        end
        if (i_cmd.mul) begin
            r_prod <= $signed({1'b0, w_env}) * r_sine;
        end
        if (i_cmd.load_out) begin
            r_sample   <= r_busy ? r_prod[actg_pkg::SAMPLE_W+14:15] : '0;
            r_busy_out <= r_busy;
        end
    end

    assign o_sample   = r_sample;
    assign o_busy_res = r_busy_out;

endmodule

`default_nettype wire
